// ===== hdl/jws_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint waypoint sequencer package
// Shared widths, types, register codes and the waypoint table.
// ----------------------------------------------------------------------------
package jws_pkg;

  localparam int JOINT_COUNT   = 4;
  localparam int PHASE_COUNT   = 8;
  localparam int WAYPOINT_ROWS = 7;
  localparam int WAYPOINT_COLS = 4;
  localparam int ANGLE_W       = 16;
  localparam int PHASE_W       = 3;
  localparam int TICK_W        = 16;
  localparam int ERR_W         = 34;
  localparam int SQ_W          = 2 * ANGLE_W;
  localparam int SUM_W         = ERR_W + 3;
  localparam int CFG_IDX_W     = 1;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [ANGLE_W-1:0]        mag_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [PHASE_W-1:0]        phase_t;
  typedef logic [TICK_W-1:0]         ticks_t;
  typedef logic [ERR_W-1:0]          err_t;
  typedef logic [SUM_W-1:0]          sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERROR_LIMIT_SQ = 1'b0,
    CFG_DWELL_TICKS    = 1'b1
  } cfg_reg_e;

  localparam phase_t HOLD_PHASE    = PHASE_W'(PHASE_COUNT - 1);
  localparam err_t   ERR_MAX       = '1;
  localparam ticks_t TICK_MAX      = '1;
  localparam err_t   ERR_LIMIT_RST = ERR_W'(1509949);
  localparam ticks_t DWELL_RST     = TICK_W'(80);

  localparam angle_t WAYPOINT_TBL [WAYPOINT_ROWS][WAYPOINT_COLS] = '{
    '{16'sd0, -16'sd4096, 16'sd4096, 16'sd0},
    '{16'sd0, -16'sd717,  16'sd4096, 16'sd0},
    '{16'sd0, 16'sd983,   16'sd6144, 16'sd2048},
    '{16'sd0, 16'sd410,   16'sd7168, 16'sd4096},
    '{16'sd0, -16'sd819,  16'sd7168, 16'sd8192},
    '{16'sd0, -16'sd2048, 16'sd5120, 16'sd8192},
    '{16'sd0, -16'sd2048, 16'sd5120, 16'sd0}
  };

  typedef struct packed {
    phase_t phase_cur;
    logic   load;
    phase_t phase_nxt;
    err_t   err;
    logic   done;
  } seq_status_t;

  function automatic angle_t waypoint(input phase_t p, input int unsigned j);
    angle_t v;
    v = '0;
    if ((int'(p) < WAYPOINT_ROWS) && (j < WAYPOINT_COLS)) begin
      v = WAYPOINT_TBL[p][j];
    end
    return v;
  endfunction

endpackage

// ===== hdl/jws_in_if.sv =====
// ----------------------------------------------------------------------------
// Measured angle channel
// Valid/ready channel carrying the four measured joint angles of one tick.
// ----------------------------------------------------------------------------
interface jws_in_if import jws_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t swing_angle;
  angle_t boom_angle;
  angle_t arm_angle;
  angle_t bucket_angle;

  modport source (output valid, output swing_angle, output boom_angle,
                  output arm_angle, output bucket_angle, input ready);
  modport sink   (input valid, input swing_angle, input boom_angle,
                  input arm_angle, input bucket_angle, output ready);
endinterface

// ===== hdl/jws_out_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying the joint targets and sequence status.
// ----------------------------------------------------------------------------
interface jws_out_if import jws_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t swing_target;
  angle_t boom_target;
  angle_t arm_target;
  angle_t bucket_target;
  phase_t phase;
  err_t   error_sq;
  logic   sequence_done;

  modport source (output valid, output swing_target, output boom_target,
                  output arm_target, output bucket_target, output phase,
                  output error_sq, output sequence_done, input ready);
  modport sink   (input valid, input swing_target, input boom_target,
                  input arm_target, input bucket_target, input phase,
                  input error_sq, input sequence_done, output ready);
endinterface

// ===== hdl/jws_lane.sv =====
// ----------------------------------------------------------------------------
// Joint lane
// Holds one joint's last command and squares its tracking error.
// ----------------------------------------------------------------------------
module jws_lane import jws_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  logic   load,
  input  angle_t reset_target,
  input  angle_t waypoint_val,
  input  angle_t angle,
  output sq_t    square,
  output angle_t target_nxt
);

  angle_t                target_r;
  logic signed [ANGLE_W:0] diff;
  logic [ANGLE_W:0]      diff_neg;
  mag_t                  mag;

  always_comb begin
    diff     = {target_r[ANGLE_W-1], target_r} - {angle[ANGLE_W-1], angle};
    diff_neg = -diff;
    mag      = diff[ANGLE_W] ? diff_neg[ANGLE_W-1:0] : diff[ANGLE_W-1:0];
    square   = mag * mag;
    target_nxt = load ? waypoint_val : target_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= reset_target;
    end else if (step) begin
      target_r <= target_nxt;
    end
  end

endmodule

// ===== hdl/jws_merge.sv =====
// ----------------------------------------------------------------------------
// Error merge and phase control
// Sums the lane squares with saturation and advances the phase.
// ----------------------------------------------------------------------------
module jws_merge import jws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  sq_t                  squares [JOINT_COUNT],
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  err_t                 cfg_wr_data,
  output seq_status_t          status
);

  err_t   error_limit_r;
  ticks_t dwell_r;
  phase_t phase_r;
  phase_t phase_nxt;
  ticks_t ticks_r;
  ticks_t ticks_nxt;
  sum_t   sum;
  err_t   err;
  logic   active;
  logic   advance;

  always_comb begin
    sum = '0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      sum = sum + SUM_W'(squares[j]);
    end
    err     = (sum > SUM_W'(ERR_MAX)) ? ERR_MAX : sum[ERR_W-1:0];
    active  = phase_r < HOLD_PHASE;
    advance = active && (err < error_limit_r) && (ticks_r > dwell_r);
    if (advance) begin
      phase_nxt = phase_r + 1'b1;
      ticks_nxt = '0;
    end else begin
      phase_nxt = phase_r;
      ticks_nxt = (ticks_r != TICK_MAX) ? ticks_r + 1'b1 : ticks_r;
    end
    status.phase_cur = phase_r;
    status.load      = active;
    status.phase_nxt = phase_nxt;
    status.err       = err;
    status.done      = phase_nxt >= HOLD_PHASE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      ticks_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_limit_r <= ERR_LIMIT_RST;
      dwell_r       <= DWELL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        CFG_ERROR_LIMIT_SQ: error_limit_r <= cfg_wr_data;
        CFG_DWELL_TICKS:    dwell_r       <= cfg_wr_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/joint_waypoint_sequencer.sv =====
// ----------------------------------------------------------------------------
// Joint waypoint sequencer
// Steps a four-joint arm through a fixed list of waypoints.
// ----------------------------------------------------------------------------
// Each beat on in_chan is one control tick with four measured joint angles.
// Each accepted beat yields exactly one beat on out_chan carrying the joint
// targets, the phase after the tick, the squared tracking error against the
// previous command and the done flag of the final holding phase.
// The four joints are handled by parallel lanes that square their errors in
// the cycle the beat is accepted; a merge stage sums them, compares against
// the limit and steps the phase. The result appears on out_chan in the
// cycle after acceptance and, while out_chan is ready, a new beat is taken
// every cycle: one tick per cycle, set by the single output register.
// When out_chan stalls, the output register holds its beat and in_chan
// accepts a beat in the same cycle the held beat is taken.
// Reset (rst_n low at a clock edge) returns phase and tick count to zero,
// loads the phase 0 waypoint as the last command and restores the default
// error limit and dwell. The user must write configuration through cfg_wr_en,
// cfg_index and cfg_wr_data while no tick is in flight; this is not checked.
// ----------------------------------------------------------------------------
module joint_waypoint_sequencer import jws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  jws_in_if.sink               in_chan,
  jws_out_if.source            out_chan,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  err_t                 cfg_wr_data
);

  logic        accept;
  angle_t      angles [JOINT_COUNT];
  sq_t         squares [JOINT_COUNT];
  angle_t      targets_nxt [JOINT_COUNT];
  seq_status_t status;

  logic        out_valid_r;
  angle_t      targets_r [JOINT_COUNT];
  phase_t      phase_r;
  err_t        err_r;
  logic        done_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign angles[0] = in_chan.swing_angle;
  assign angles[1] = in_chan.boom_angle;
  assign angles[2] = in_chan.arm_angle;
  assign angles[3] = in_chan.bucket_angle;

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_lane
    jws_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .step         (accept),
      .load         (status.load),
      .reset_target (waypoint('0, j)),
      .waypoint_val (waypoint(status.phase_cur, j)),
      .angle        (angles[j]),
      .square       (squares[j]),
      .target_nxt   (targets_nxt[j])
    );
  end

  jws_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .squares     (squares),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      targets_r <= targets_nxt;
      phase_r   <= status.phase_nxt;
      err_r     <= status.err;
      done_r    <= status.done;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.swing_target  = targets_r[0];
  assign out_chan.boom_target   = targets_r[1];
  assign out_chan.arm_target    = targets_r[2];
  assign out_chan.bucket_target = targets_r[3];
  assign out_chan.phase         = phase_r;
  assign out_chan.error_sq      = err_r;
  assign out_chan.sequence_done = done_r;

endmodule

// ===== hdl/jws_checker.sv =====
// ----------------------------------------------------------------------------
// Joint waypoint sequencer checker
// Port-level assertions on the command channel, bound to the top level.
// ----------------------------------------------------------------------------
module jws_checker import jws_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   out_valid,
  input logic   out_ready,
  input phase_t phase,
  input err_t   error_sq,
  input logic   sequence_done
);

  a_done_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sequence_done == (phase == HOLD_PHASE)))
    else $error("sequence_done disagrees with phase");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(phase) && $stable(error_sq)))
    else $error("stalled command beat changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("command beat valid after reset");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && sequence_done) |=> (!out_valid || sequence_done))
    else $error("sequence left the holding phase");

endmodule

bind joint_waypoint_sequencer jws_checker u_jws_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .phase         (out_chan.phase),
  .error_sq      (out_chan.error_sq),
  .sequence_done (out_chan.sequence_done)
);

// ===== tb/joint_waypoint_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// Joint waypoint sequencer testbench
// Feeds measured-angle ticks through a valid/ready driver, predicts each
// command beat with an independent model of the phase sequencer, and checks
// every beat on the command channel field by field. The run covers directed
// extremes, a dwell too long for any phase to advance, and random register
// settings with mostly tracking measurements so that the sequence advances
// through every phase into the final hold.
// ----------------------------------------------------------------------------
module joint_waypoint_sequencer_tb;
  import jws_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint unsigned ERR_SAT = (64'd1 << 34) - 1;
  localparam phase_t FINAL_PHASE = 3'd7;
  localparam err_t LIMIT_DEFAULT = 34'd1509949;
  localparam ticks_t DWELL_DEFAULT = 16'd80;

  typedef struct packed {
    angle_t swing;
    angle_t boom;
    angle_t arm;
    angle_t bucket;
  } meas_tick_t;

  typedef struct packed {
    angle_t swing;
    angle_t boom;
    angle_t arm;
    angle_t bucket;
    phase_t phase;
    err_t   err;
    logic   done;
  } cmd_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  err_t cfg_wr_data;

  jws_in_if  in_if ();
  jws_out_if out_if ();

  joint_waypoint_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  meas_tick_t meas_q[$];
  cmd_beat_t  cmd_due_q[$];

  phase_t seq_phase;
  ticks_t seq_ticks;
  angle_t track_cmd [JOINT_COUNT];
  err_t   cfg_limit;
  ticks_t cfg_dwell;

  int unsigned queued_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned settings_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic ticks_saturated = 1'b0;

  always #6 clk = ~clk;

  function automatic angle_t setpoint(input phase_t row, input int col);
    logic signed [0:3][31:0] row_mrad;
    int mrad;
    longint mag;
    longint q;
    case (row)
      3'd0: row_mrad = {32'sd0, -32'sd1000, 32'sd1000, 32'sd0};
      3'd1: row_mrad = {32'sd0, -32'sd175, 32'sd1000, 32'sd0};
      3'd2: row_mrad = {32'sd0, 32'sd240, 32'sd1500, 32'sd500};
      3'd3: row_mrad = {32'sd0, 32'sd100, 32'sd1750, 32'sd1000};
      3'd4: row_mrad = {32'sd0, -32'sd200, 32'sd1750, 32'sd2000};
      3'd5: row_mrad = {32'sd0, -32'sd500, 32'sd1250, 32'sd2000};
      3'd6: row_mrad = {32'sd0, -32'sd500, 32'sd1250, 32'sd0};
      default: row_mrad = '0;
    endcase
    mrad = (col < 4) ? int'(signed'(row_mrad[col])) : 0;
    mag = (mrad < 0) ? -longint'(mrad) : longint'(mrad);
    q = (mag * 4096 + 500) / 1000;
    if (mrad < 0) begin
      if (q > 32768) q = 32768;
      return angle_t'(-q);
    end
    if (q > 32767) q = 32767;
    return angle_t'(q);
  endfunction

  function automatic cmd_beat_t step_sequence(input meas_tick_t t);
    angle_t meas [JOINT_COUNT];
    longint d;
    longint unsigned sum;
    cmd_beat_t r;
    meas[0] = t.swing;
    meas[1] = t.boom;
    meas[2] = t.arm;
    meas[3] = t.bucket;
    sum = 0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      d = longint'(track_cmd[j]) - longint'(meas[j]);
      sum = sum + longint'(d * d);
      if (sum > ERR_SAT) sum = ERR_SAT;
    end
    if (seq_phase < FINAL_PHASE) begin
      for (int j = 0; j < JOINT_COUNT; j++) track_cmd[j] = setpoint(seq_phase, j);
      if (sum < longint'(cfg_limit) && seq_ticks > cfg_dwell) begin
        seq_phase = seq_phase + 3'd1;
        seq_ticks = '0;
      end else if (seq_ticks != 16'hFFFF) begin
        seq_ticks = seq_ticks + 16'd1;
      end
    end else if (seq_ticks != 16'hFFFF) begin
      seq_ticks = seq_ticks + 16'd1;
    end
    if (seq_ticks == 16'hFFFF) ticks_saturated = 1'b1;
    r.swing = track_cmd[0];
    r.boom = track_cmd[1];
    r.arm = track_cmd[2];
    r.bucket = track_cmd[3];
    r.phase = seq_phase;
    r.err = err_t'(sum);
    r.done = (seq_phase >= FINAL_PHASE);
    return r;
  endfunction

  function automatic meas_tick_t track_tick(input int spread);
    angle_t m [JOINT_COUNT];
    int v;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      v = int'(track_cmd[j]) + int'($urandom_range(2 * spread, 0)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      m[j] = angle_t'(v);
    end
    return {m[0], m[1], m[2], m[3]};
  endfunction

  function automatic meas_tick_t mixed_tick();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return meas_tick_t'({$urandom, $urandom});
    if (pick < 50) return track_tick(0);
    if (pick < 75) return track_tick(40);
    return track_tick(400);
  endfunction

  task automatic queue_tick(input meas_tick_t t);
    while (meas_q.size() >= 2) @(posedge clk);
    meas_q.push_back(t);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sent_cnt != queued_cnt || cmd_due_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input err_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_ERROR_LIMIT_SQ) cfg_limit = val;
    else cfg_dwell = val[15:0];
    settings_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        cmd_due_q.push_back(step_sequence({in_if.swing_angle, in_if.boom_angle,
                                           in_if.arm_angle, in_if.bucket_angle}));
        sent_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (meas_q.size() != 0 &&
            ((sent_cnt >= 150 && sent_cnt < 350) || $urandom_range(99) >= 28)) begin
          meas_tick_t t;
          t = meas_q.pop_front();
          in_if.swing_angle <= t.swing;
          in_if.boom_angle <= t.boom;
          in_if.arm_angle <= t.arm;
          in_if.bucket_angle <= t.bucket;
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (recv_cnt >= 150 && recv_cnt < 350) || ($urandom_range(99) >= 28);
      if (out_if.valid && out_if.ready) begin
        cmd_beat_t got;
        cmd_beat_t want;
        got = {out_if.swing_target, out_if.boom_target, out_if.arm_target,
               out_if.bucket_target, out_if.phase, out_if.error_sq, out_if.sequence_done};
        recv_cnt++;
        if (cmd_due_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("Command beat %0d arrived with none expected", recv_cnt);
        end else begin
          want = cmd_due_q.pop_front();
          if (got.swing !== want.swing || got.boom !== want.boom || got.arm !== want.arm ||
              got.bucket !== want.bucket || got.phase !== want.phase ||
              got.err !== want.err || got.done !== want.done) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("Beat %0d expected targets %0d %0d %0d %0d phase %0d err %0d done %0d",
                       recv_cnt, want.swing, want.boom, want.arm, want.bucket,
                       want.phase, want.err, want.done);
              $display("Beat %0d actual   targets %0d %0d %0d %0d phase %0d err %0d done %0d",
                       recv_cnt, got.swing, got.boom, got.arm, got.bucket,
                       got.phase, got.err, got.done);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    err_t lim;
    ticks_t dw;
    int n;
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.swing_angle = '0;
    in_if.boom_angle = '0;
    in_if.arm_angle = '0;
    in_if.bucket_angle = '0;
    out_if.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_ERROR_LIMIT_SQ;
    cfg_wr_data = '0;
    seq_phase = '0;
    seq_ticks = '0;
    cfg_limit = LIMIT_DEFAULT;
    cfg_dwell = DWELL_DEFAULT;
    for (int j = 0; j < JOINT_COUNT; j++) track_cmd[j] = setpoint(3'd0, j);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    repeat (3) queue_tick(track_tick(0));
    queue_tick({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    queue_tick({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    queue_tick({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
    queue_tick({16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    queue_tick({16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA});
    queue_tick({16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555});
    queue_tick({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    queue_tick({16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF});
    repeat (5) queue_tick(track_tick(10));

    // A huge dwell blocks every advance even with the loosest limit.
    wait_drained();
    write_reg(CFG_ERROR_LIMIT_SQ, '1);
    write_reg(CFG_DWELL_TICKS, 34'd65535);
    repeat (30) queue_tick(mixed_tick());

    wait_drained();
    write_reg(CFG_DWELL_TICKS, 34'd3);
    repeat (10) queue_tick(track_tick(0));

    for (int c = 0; c < 8; c++) begin
      wait_drained();
      case (c == 0 ? 1 : $urandom_range(4))
        0: begin lim = '1; dw = '0; end
        1: begin lim = '0; dw = ticks_t'($urandom_range(20)); end
        2: begin lim = LIMIT_DEFAULT; dw = ticks_t'($urandom_range(30, 2)); end
        3: begin lim = err_t'({$urandom, $urandom}); dw = ticks_t'($urandom_range(40)); end
        default: begin lim = err_t'($urandom_range(4000000, 1)); dw = ticks_t'($urandom_range(10, 1)); end
      endcase
      write_reg(CFG_ERROR_LIMIT_SQ, lim);
      write_reg(CFG_DWELL_TICKS, {18'd0, dw});
      n = $urandom_range(55, 35);
      repeat (n) queue_tick(mixed_tick());
    end

    wait_drained();
    write_reg(CFG_ERROR_LIMIT_SQ, '1);
    write_reg(CFG_DWELL_TICKS, '0);
    repeat (20) queue_tick(track_tick(0));
    repeat (10) queue_tick(mixed_tick());

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Checked %0d command beats across %0d register writes; final phase %0d.",
             recv_cnt, settings_cnt, seq_phase);
    $display("Tick counter saturation %0s; %0d mismatches, %0d beats still expected.",
             ticks_saturated ? "reached" : "not reached", mismatch_cnt, cmd_due_q.size());
    if (mismatch_cnt == 0 && cmd_due_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
